// ===== design/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic spline point evaluator package
// Shared constants, codes and control types of the spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

   // Default parameter values.
   localparam int KNOT_DEPTH_DEF = 256;
   localparam int COORD_BITS_DEF = 32;

   // Fixed field widths.
   localparam int FUNC_W     = 2;
   localparam int INDEX_W    = 8;
   localparam int U_W        = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int COUNT_W    = 9;

   // Fraction u is Q1.16; one is 2^16.
   localparam int U_FRAC = 16;
   localparam logic [U_W-1:0] U_ONE = U_W'(65536);

   // Basis weight scales of the two modes.
   localparam int SHIFT_CATMULL = 50;
   localparam int SHIFT_HERMITE = 48;

   // Smallest usable knot count.
   localparam int MIN_POINTS = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_MODE        = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 1'd1;

   // Reset values of the registers.
   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = COUNT_W'(3);

   // Basis selection.
   localparam logic MODE_CATMULL = 1'b0;
   localparam logic MODE_HERMITE = 1'b1;

   // Request function codes.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WR_KNOT = 2'd0,
      FUNC_WR_TAN  = 2'd1,
      FUNC_EVAL    = 2'd2
   } func_type;

   // Control word of one queued item.
   typedef struct packed {
      func_type       kind;
      logic           err;
      logic           herm;
      logic           idx0;
      logic [U_W-1:0] u;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== design/csp_if.sv =====
// ----------------------------------------------------------------------------
// Cubic spline point evaluator channels
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csp_req_if #(
   parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) ();
   logic                            valid;
   logic                            ready;
   logic [csp_pkg::FUNC_W-1:0]      func;
   logic [csp_pkg::INDEX_W-1:0]     index;
   logic signed [COORD_BITS-1:0]    coord_x;
   logic signed [COORD_BITS-1:0]    coord_y;
   logic signed [COORD_BITS-1:0]    coord_z;
   logic [csp_pkg::U_W-1:0]         u;

   modport source (output valid, func, index, coord_x, coord_y, coord_z, u,
                   input ready);
   modport sink   (input valid, func, index, coord_x, coord_y, coord_z, u,
                   output ready);
endinterface

interface csp_rsp_if #(
   parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic                         range_error;

   modport source (output valid, pos_x, pos_y, pos_z, range_error, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, range_error, output ready);
endinterface

interface csp_csr_if ();
   logic                            valid;
   logic                            ready;
   logic [csp_pkg::CSR_IDX_W-1:0]   index;
   logic [csp_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/csp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// At most one write and one read per cycle at one shared address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Storage array and read register; the read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/csp_front.sv =====
// ----------------------------------------------------------------------------
// Spline evaluator front end
// Holds the registers, classifies requests and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_front #(
   parameter int KNOT_DEPTH = csp_pkg::KNOT_DEPTH_DEF,
   parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   csp_req_if.sink                    req_ch,
   csp_csr_if.sink                    csr_ch,
   output logic                       q_valid,
   output csp_pkg::ctrl_type          q_ctrl,
   output logic [3:0][$clog2(KNOT_DEPTH)-1:0] q_addr,
   output logic [2:0][COORD_BITS-1:0] q_data,
   input  wire logic                  q_pop
);

   localparam int AW     = $clog2(KNOT_DEPTH);
   localparam int CNTW   = $clog2(KNOT_DEPTH + 1);
   localparam int NW     = (CNTW > csp_pkg::COUNT_W) ? CNTW : csp_pkg::COUNT_W;
   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);
   localparam logic [NW-1:0]  DEPTH_N = NW'(KNOT_DEPTH);
   localparam logic [NW-1:0]  MIN_N   = NW'(csp_pkg::MIN_POINTS);
   localparam logic [QCW-1:0] Q_FULL  = QCW'(QDEPTH);

   logic                          mode_ff, mode_in;
   logic [csp_pkg::COUNT_W-1:0]   pc_ff, pc_in;

   logic [NW-1:0]         pc_ext, n_eff, idx_ext, idx_p1, idx_m1, nx, nx_p1, fu;
   logic                  cm_err, hm_err, wr_ok, keep;
   csp_pkg::ctrl_type     cls_ctrl;
   logic [3:0][AW-1:0]    cls_addr;

   csp_pkg::ctrl_type     ent_ctrl_ff [QDEPTH];
   logic [3:0][AW-1:0]    ent_addr_ff [QDEPTH];
   logic [2:0][COORD_BITS-1:0] ent_data_ff [QDEPTH];
   logic [QPW-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]        count_ff, count_in;
   logic                  push;

   // Register writes.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      pc_in   = pc_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            csp_pkg::REG_MODE:        mode_in = csr_ch.data[0];
            csp_pkg::REG_POINT_COUNT: pc_in   = csr_ch.data;
            default:                  mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csp_pkg::MODE_CATMULL;
         pc_ff   <= csp_pkg::POINT_COUNT_RESET;
      end else begin
         mode_ff <= mode_in;
         pc_ff   <= pc_in;
      end
   end

   // Segment range checks and knot addresses.
   always_comb begin
      pc_ext  = NW'(pc_ff);
      n_eff   = (pc_ext < MIN_N) ? MIN_N : ((pc_ext > DEPTH_N) ? DEPTH_N : pc_ext);
      idx_ext = NW'(req_ch.index);
      idx_p1  = idx_ext + NW'(1);
      idx_m1  = idx_ext - NW'(1);
      cm_err  = idx_ext >= n_eff;
      hm_err  = idx_p1 >= n_eff;
      nx      = hm_err ? '0 : idx_p1;
      nx_p1   = nx + NW'(1);
      fu      = (nx_p1 >= n_eff) ? '0 : nx_p1;
      wr_ok   = idx_ext < DEPTH_N;
   end

   // Classification of the request into a queue entry.
   always_comb begin
      cls_ctrl.kind = csp_pkg::FUNC_EVAL;
      cls_ctrl.herm = mode_ff == csp_pkg::MODE_HERMITE;
      cls_ctrl.err  = (mode_ff == csp_pkg::MODE_HERMITE) ? hm_err : cm_err;
      cls_ctrl.idx0 = idx_ext == '0;
      cls_ctrl.u    = (req_ch.u > csp_pkg::U_ONE) ? csp_pkg::U_ONE : req_ch.u;
      keep          = 1'b0;
      if (mode_ff == csp_pkg::MODE_HERMITE) begin
         cls_addr[0] = idx_ext[AW-1:0];
         cls_addr[1] = idx_p1[AW-1:0];
         cls_addr[2] = idx_ext[AW-1:0];
         cls_addr[3] = idx_ext[AW-1:0];
      end else begin
         cls_addr[0] = cls_ctrl.idx0 ? idx_ext[AW-1:0] : idx_m1[AW-1:0];
         cls_addr[1] = idx_ext[AW-1:0];
         cls_addr[2] = nx[AW-1:0];
         cls_addr[3] = fu[AW-1:0];
      end
      case (req_ch.func)
         csp_pkg::FUNC_WR_KNOT: begin
            cls_ctrl.kind = csp_pkg::FUNC_WR_KNOT;
            keep          = wr_ok;
         end
         csp_pkg::FUNC_WR_TAN: begin
            cls_ctrl.kind = csp_pkg::FUNC_WR_TAN;
            keep          = wr_ok;
         end
         csp_pkg::FUNC_EVAL: begin
            keep          = 1'b1;
         end
         default: begin
            keep          = 1'b0;
         end
      endcase
      if (cls_ctrl.kind != csp_pkg::FUNC_EVAL) begin
         cls_addr[0] = idx_ext[AW-1:0];
      end
   end

   // Two-entry queue toward the back end.
   assign req_ch.ready = count_ff != Q_FULL;
   assign push         = req_ch.valid && req_ch.ready && keep;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCW'(push) - QCW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ctrl_ff[wr_ptr_ff] <= cls_ctrl;
         ent_addr_ff[wr_ptr_ff] <= cls_addr;
         ent_data_ff[wr_ptr_ff] <= {req_ch.coord_z, req_ch.coord_y, req_ch.coord_x};
      end
   end

   assign q_valid = count_ff != '0;
   assign q_ctrl  = ent_ctrl_ff[rd_ptr_ff];
   assign q_addr  = ent_addr_ff[rd_ptr_ff];
   assign q_data  = ent_data_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== design/csp_lane.sv =====
// ----------------------------------------------------------------------------
// Spline evaluator axis lane
// Basis coefficients, three Horner multiply stages in u, rounding and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_lane #(
   parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic                         herm,
   input  wire logic                         idx0,
   input  wire logic [csp_pkg::U_W-1:0]      u,
   input  wire logic signed [COORD_BITS-1:0] k0,
   input  wire logic signed [COORD_BITS-1:0] k1,
   input  wire logic signed [COORD_BITS-1:0] k2,
   input  wire logic signed [COORD_BITS-1:0] k3,
   input  wire logic signed [COORD_BITS-1:0] t0,
   input  wire logic signed [COORD_BITS-1:0] t1,
   output logic signed [COORD_BITS-1:0]      pos
);

   localparam int W   = COORD_BITS;
   localparam int CW  = W + 7;
   localparam int UW  = csp_pkg::U_W + 1;
   localparam int P1W = CW + UW + 1;
   localparam int P2W = P1W + UW + 1;
   localparam int P3W = P2W + UW + 1;
   localparam logic signed [P3W-1:0] MAXV = (P3W'(1) <<< (W - 1)) - P3W'(1);
   localparam logic signed [P3W-1:0] MINV = -(P3W'(1) <<< (W - 1));
   localparam logic signed [P3W-1:0] HALF_C = P3W'(1) <<< (csp_pkg::SHIFT_CATMULL - 1);
   localparam logic signed [P3W-1:0] HALF_H = P3W'(1) <<< (csp_pkg::SHIFT_HERMITE - 1);

   logic signed [CW-1:0] e0, e1, e2, e3, et0, et1, p1, p2, p3, h;
   logic signed [CW-1:0] ca_in, cb_in, cc_in, cd_in;
   logic signed [CW-1:0] ca_ff, cb_ff, cc_ff, cd_ff, c2_ff, d2_ff, d3_ff;
   logic [csp_pkg::U_W-1:0] u0_ff, u1_ff, u2_ff;
   logic herm0_ff, herm1_ff, herm2_ff, herm3_ff;
   logic signed [CW+UW-1:0]  prod1;
   logic signed [P1W+UW-1:0] prod2;
   logic signed [P2W+UW-1:0] prod3;
   logic signed [P1W-1:0] acc1_ff, acc1_in;
   logic signed [P2W-1:0] acc2_ff, acc2_in;
   logic signed [P3W-1:0] acc3_ff, acc3_in;
   logic signed [P3W-1:0] rnd_c, rnd_h, rnd;

   // Coefficients of the cubic in u for the selected basis.
   always_comb begin
      e0  = CW'(k0);
      e1  = CW'(k1);
      e2  = CW'(k2);
      e3  = CW'(k3);
      et0 = CW'(t0);
      et1 = CW'(t1);
      p1  = e1 <<< 1;
      p2  = e2 <<< 1;
      p3  = e3 <<< 1;
      // The previous point at knot 0 is formed from knots 0, 1 and 2.
      h   = idx0 ? ((e2 <<< 1) + e2 - (e3 <<< 1) - (e1 <<< 1)) : (e0 <<< 1);
      if (herm) begin
         ca_in = (e0 <<< 1) - (e1 <<< 1) + et0 + et1;
         cb_in = (e1 <<< 1) + e1 - (e0 <<< 1) - e0 - (et0 <<< 1) - et1;
         cc_in = et0;
         cd_in = e0;
      end else begin
         ca_in = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - h;
         cb_in = (h <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
         cc_in = p2 - h;
         cd_in = p1 <<< 1;
      end
   end

   // Horner steps: one multiply by u per stage.
   always_comb begin
      prod1   = ca_ff * $signed({1'b0, u0_ff});
      acc1_in = P1W'(prod1) + (P1W'(cb_ff) <<< csp_pkg::U_FRAC);
      prod2   = acc1_ff * $signed({1'b0, u1_ff});
      acc2_in = P2W'(prod2) + (P2W'(c2_ff) <<< (2 * csp_pkg::U_FRAC));
      prod3   = acc2_ff * $signed({1'b0, u2_ff});
      acc3_in = P3W'(prod3) + (P3W'(d3_ff) <<< (3 * csp_pkg::U_FRAC));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ca_ff    <= ca_in;
         cb_ff    <= cb_in;
         cc_ff    <= cc_in;
         cd_ff    <= cd_in;
         u0_ff    <= u;
         herm0_ff <= herm;
         acc1_ff  <= acc1_in;
         c2_ff    <= cc_ff;
         d2_ff    <= cd_ff;
         u1_ff    <= u0_ff;
         herm1_ff <= herm0_ff;
         acc2_ff  <= acc2_in;
         d3_ff    <= d2_ff;
         u2_ff    <= u1_ff;
         herm2_ff <= herm1_ff;
         acc3_ff  <= acc3_in;
         herm3_ff <= herm2_ff;
      end
   end

   // Round half up at the scale of the basis, then clamp to the coordinate range.
   always_comb begin
      rnd_c = (acc3_ff + HALF_C) >>> csp_pkg::SHIFT_CATMULL;
      rnd_h = (acc3_ff + HALF_H) >>> csp_pkg::SHIFT_HERMITE;
      rnd   = herm3_ff ? rnd_h : rnd_c;
      if (rnd > MAXV) begin
         pos = MAXV[W-1:0];
      end else if (rnd < MINV) begin
         pos = MINV[W-1:0];
      end else begin
         pos = rnd[W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== design/csp_back.sv =====
// ----------------------------------------------------------------------------
// Spline evaluator back end
// Knot and tangent stores, read sequencer, axis lanes and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_back #(
   parameter int KNOT_DEPTH = csp_pkg::KNOT_DEPTH_DEF,
   parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire csp_pkg::ctrl_type           q_ctrl,
   input  wire logic [3:0][$clog2(KNOT_DEPTH)-1:0] q_addr,
   input  wire logic [2:0][COORD_BITS-1:0]  q_data,
   output logic                             q_pop,
   csp_rsp_if.source                        rsp_ch
);

   localparam int AW = $clog2(KNOT_DEPTH);
   localparam int W  = COORD_BITS;
   localparam logic [1:0] LAST_SLOT = 2'd3;

   logic en, is_eval, we_k, we_t, re;
   logic [AW-1:0] ram_addr;
   logic [2:0][W-1:0] knot_rd, tan_rd;
   logic [1:0] slot_ff, slot_in;

   logic cap_v_ff, cap_v_in;
   logic [1:0] cap_slot_ff;
   csp_pkg::ctrl_type cap_ctrl_ff;
   logic [2:0][2:0][W-1:0] kreg_ff;
   logic [1:0][2:0][W-1:0] treg_ff;
   logic cap_last;

   logic [3:0] vpipe_ff, vpipe_in;
   logic [3:0] epipe_ff;
   logic [2:0][W-1:0] lane_pos;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0][W-1:0] pos_ff;
   logic err_ff;

   // Whole pipeline advances unless a result waits at the output.
   assign en      = !rsp_valid_ff || rsp_ch.ready;
   assign is_eval = q_valid && (q_ctrl.kind == csp_pkg::FUNC_EVAL);
   assign we_k    = en && q_valid && (q_ctrl.kind == csp_pkg::FUNC_WR_KNOT);
   assign we_t    = en && q_valid && (q_ctrl.kind == csp_pkg::FUNC_WR_TAN);
   assign re      = en && is_eval;
   assign q_pop   = en && q_valid && (!is_eval || slot_ff == LAST_SLOT);
   assign ram_addr = is_eval ? q_addr[slot_ff] : q_addr[0];
   assign slot_in  = re ? slot_ff + 2'd1 : slot_ff;

   // Knot and tangent stores, x, y and z side by side.
   csp_ram #(.WIDTH(3 * W), .DEPTH(KNOT_DEPTH)) u_knot_ram (
      .clock (clock),
      .we    (we_k),
      .re    (re),
      .addr  (ram_addr),
      .wdata (q_data),
      .rdata (knot_rd)
   );

   csp_ram #(.WIDTH(3 * W), .DEPTH(KNOT_DEPTH)) u_tan_ram (
      .clock (clock),
      .we    (we_t),
      .re    (re),
      .addr  (ram_addr),
      .wdata (q_data),
      .rdata (tan_rd)
   );

   // Read slot sequencing and capture of the returned knots.
   assign cap_v_in = en ? re : cap_v_ff;
   assign cap_last = cap_v_ff && (cap_slot_ff == LAST_SLOT);

   always_comb begin
      vpipe_in = vpipe_ff;
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         vpipe_in     = {vpipe_ff[2:0], cap_last};
         rsp_valid_in = vpipe_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         cap_v_ff     <= 1'b0;
         vpipe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         cap_v_ff     <= cap_v_in;
         vpipe_ff     <= vpipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cap_slot_ff <= slot_ff;
         cap_ctrl_ff <= q_ctrl;
         if (cap_v_ff && cap_slot_ff == 2'd0) begin
            kreg_ff[0] <= knot_rd;
            treg_ff[0] <= tan_rd;
         end
         if (cap_v_ff && cap_slot_ff == 2'd1) begin
            kreg_ff[1] <= knot_rd;
            treg_ff[1] <= tan_rd;
         end
         if (cap_v_ff && cap_slot_ff == 2'd2) begin
            kreg_ff[2] <= knot_rd;
         end
         epipe_ff <= {epipe_ff[2:0], cap_ctrl_ff.err};
         pos_ff   <= epipe_ff[3] ? '0 : lane_pos;
         err_ff   <= epipe_ff[3];
      end
   end

   // One arithmetic lane per axis.
   for (genvar ax = 0; ax < 3; ax++) begin : g_lane
      csp_lane #(.COORD_BITS(W)) u_lane (
         .clock (clock),
         .en    (en),
         .herm  (cap_ctrl_ff.herm),
         .idx0  (cap_ctrl_ff.idx0),
         .u     (cap_ctrl_ff.u),
         .k0    ($signed(kreg_ff[0][ax])),
         .k1    ($signed(kreg_ff[1][ax])),
         .k2    ($signed(kreg_ff[2][ax])),
         .k3    ($signed(knot_rd[ax])),
         .t0    ($signed(treg_ff[0][ax])),
         .t1    ($signed(treg_ff[1][ax])),
         .pos   (lane_pos[ax])
      );
   end

   // Result register.
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pos_x       = pos_ff[0];
   assign rsp_ch.pos_y       = pos_ff[1];
   assign rsp_ch.pos_z       = pos_ff[2];
   assign rsp_ch.range_error = err_ff;

endmodule

`default_nettype wire

// ===== design/cubic_spline_point_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// Cubic spline point evaluator
// Catmull-Rom and Hermite evaluation of 3-D positions on a knot table.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req_ch   in         func, index, coord_x/y/z, u
//  rsp_ch   out        pos_x/y/z, range_error
//  csr_ch   in         register index, write data
//
// An evaluate reads the single-ported knot store once for each of its four
// knots in turn, and the queue holds the next request until its last read.
// A knot or tangent write takes a single access of the store.
// After the last read, the coefficient, Horner and result registers follow.
// Reset clears control state only; the stores are not cleared.
// A stalled result freezes the back end; requests still fill the queue.
`default_nettype none

module cubic_spline_point_evaluator_unit #(
   parameter int KNOT_DEPTH = csp_pkg::KNOT_DEPTH_DEF,
   parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   csp_req_if.sink    req_ch,
   csp_rsp_if.source  rsp_ch,
   csp_csr_if.sink    csr_ch
);

   localparam int AW = $clog2(KNOT_DEPTH);

   logic                       q_valid;
   logic                       q_pop;
   csp_pkg::ctrl_type          q_ctrl;
   logic [3:0][AW-1:0]         q_addr;
   logic [2:0][COORD_BITS-1:0] q_data;

   // Front end: registers, classification and queue.
   csp_front #(.KNOT_DEPTH(KNOT_DEPTH), .COORD_BITS(COORD_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .csr_ch  (csr_ch),
      .q_valid (q_valid),
      .q_ctrl  (q_ctrl),
      .q_addr  (q_addr),
      .q_data  (q_data),
      .q_pop   (q_pop)
   );

   // Back end: stores and arithmetic.
   csp_back #(.KNOT_DEPTH(KNOT_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ctrl  (q_ctrl),
      .q_addr  (q_addr),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== design/csp_checker.sv =====
// ----------------------------------------------------------------------------
// Spline evaluator port checker
// Checks on the result channel of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_checker #(
   parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] pos_x,
   input wire logic [COORD_BITS-1:0] pos_y,
   input wire logic [COORD_BITS-1:0] pos_z,
   input wire logic                  range_error
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(pos_y)
         && $stable(pos_z) && $stable(range_error))
      else $error("result changed while stalled");

   // A range error carries a zero position.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && range_error |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
      else $error("range error with nonzero position");

   // Reset empties the result register.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Results are spaced by the store reads, so none follows a transfer at once.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result follows a transfer too soon");

endmodule

bind cubic_spline_point_evaluator_unit csp_checker #(.COORD_BITS(COORD_BITS)) u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .pos_x       (rsp_ch.pos_x),
   .pos_y       (rsp_ch.pos_y),
   .pos_z       (rsp_ch.pos_z),
   .range_error (rsp_ch.range_error)
);

`default_nettype wire
